### rtl/core/ipr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Isolated pixel removal package
// Shared types and constants for the isolated pixel removal block.
// ----------------------------------------------------------------------------
package ipr_pkg;

    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [FH_W-1:0] HEIGHT_LIMIT     = 13'd4096;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam int         WIN_CENTER        = 4;
    localparam logic [8:0] WIN_NEIGHBOR_MASK = 9'h1EF;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 4'd0,
        REG_FRAME_HEIGHT = 4'd1
    } cfg_reg_t;

    typedef struct packed {
        logic px;
        logic top_en;
        logic mid_en;
        logic wr;
        logic at_edge;
        logic at_col0;
        logic res;
        logic last;
        logic extra;
        logic clr;
    } ipr_op_t;

    typedef struct packed {
        logic pixel_out;
        logic frame_last;
    } ipr_res_t;

endpackage

### rtl/core/ipr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Isolated pixel removal channels
// Valid/ready channels for pixels in, filtered pixels out and register writes.
// ----------------------------------------------------------------------------
interface ipr_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic pixel_in;

    modport source (output valid, output kind, output pixel_in, input ready);
    modport sink (input valid, input kind, input pixel_in, output ready);
endinterface

interface ipr_out_if;
    logic valid;
    logic ready;
    logic pixel_out;
    logic frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface ipr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ipr_pkg::CFG_IDX_W-1:0]  index;
    logic [ipr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/ipr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Isolated pixel removal sequencer
// Frame registers, raster/flush counters; one op per item but a stray flush.
// ----------------------------------------------------------------------------
module ipr_seq #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr,
    input  logic [ipr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           accept,
    input  logic                           kind,
    input  logic                           pixel_in,
    output logic [$clog2(MAX_WIDTH)-1:0]   rd_idx,
    output logic                           op_valid,
    output ipr_pkg::ipr_op_t               op,
    output logic [$clog2(MAX_WIDTH)-1:0]   op_idx
);
    import ipr_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W = $clog2(MAX_WIDTH + 2);

    logic [FW_W-1:0]   fw_reg;
    logic [FH_W-1:0]   fh_reg;
    logic [WID_W-1:0]  w_used;
    logic [FH_W-1:0]   h_used;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              col_end, row_end, last;
    logic              op_valid_reg, op_valid_next;
    ipr_op_t           op_reg, op_next;
    logic [COL_W-1:0]  op_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FRAME_WIDTH_RST;
            fh_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_reg <= cfg_data[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (fw_reg == '0)
            w_used = WID_W'(1);
        else if (32'(fw_reg) > MAX_WIDTH)
            w_used = WID_W'(MAX_WIDTH);
        else
            w_used = WID_W'(fw_reg);

        if (fh_reg == '0)
            h_used = FH_W'(1);
        else if (fh_reg > HEIGHT_LIMIT)
            h_used = HEIGHT_LIMIT;
        else
            h_used = fh_reg;
    end

    assign col_end = (WID_W'(col_reg) + WID_W'(1)) >= w_used;
    assign row_end = (FH_W'(row_reg) + FH_W'(1)) >= h_used;
    assign last    = pend_reg == PEND_W'(1);

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        pend_next     = pend_reg;
        op_valid_next = 1'b0;
        op_next       = '0;
        if (accept)
        begin
            if (pend_reg == '0)
            begin
                if (kind == KIND_PIXEL)
                begin
                    op_valid_next  = 1'b1;
                    op_next.px     = pixel_in;
                    op_next.top_en = row_reg >= ROW_W'(2);
                    op_next.mid_en = row_reg != '0;
                    op_next.wr     = 1'b1;
                    op_next.at_edge = col_reg == '0;
                    op_next.at_col0 = col_reg == '0;
                    op_next.res    = (row_reg != '0 && col_reg != '0)
                                     || (row_reg >= ROW_W'(2) && col_reg == '0);
                    if (col_end)
                    begin
                        col_next = '0;
                        if (row_end)
                        begin
                            pend_next = PEND_W'(w_used) + PEND_W'(1);
                            if (row_reg == '0)
                            begin
                                op_next.extra = 1'b1;
                                col_next  = (w_used > WID_W'(1)) ? COL_W'(1) : '0;
                                pend_next = PEND_W'(w_used);
                            end
                        end
                        else
                            row_next = row_reg + ROW_W'(1);
                    end
                    else
                        col_next = col_reg + COL_W'(1);
                end
            end
            else
            begin
                op_valid_next   = 1'b1;
                op_next.top_en  = row_reg != '0;
                op_next.mid_en  = 1'b1;
                op_next.at_edge = (col_reg == '0) || last;
                op_next.at_col0 = col_reg == '0;
                op_next.res     = 1'b1;
                op_next.last    = last;
                op_next.clr     = last;
                pend_next       = pend_reg - PEND_W'(1);
                if (last)
                begin
                    row_next = '0;
                    col_next = '0;
                end
                else
                    col_next = col_end ? '0 : col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            pend_reg     <= '0;
            op_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            pend_reg     <= pend_next;
            op_valid_reg <= op_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_valid_next)
        begin
            op_reg     <= op_next;
            op_idx_reg <= col_reg;
        end
    end

    assign rd_idx   = col_reg;
    assign op_valid = op_valid_reg;
    assign op       = op_reg;
    assign op_idx   = op_idx_reg;

endmodule

### rtl/core/ipr_lines.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Isolated pixel removal line stores
// Upper and middle row memories with registered reads and write forwarding.
// ----------------------------------------------------------------------------
module ipr_lines #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_idx,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_idx,
    input  logic                         wr_px,
    output logic                         up_raw,
    output logic                         mid_raw
);
    logic upper_mem  [MAX_WIDTH];
    logic middle_mem [MAX_WIDTH];
    logic up_rd_reg, mid_rd_reg;
    logic fwd_reg, fwd_up_reg, fwd_mid_reg;

    assign up_raw  = fwd_reg ? fwd_up_reg : up_rd_reg;
    assign mid_raw = fwd_reg ? fwd_mid_reg : mid_rd_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            up_rd_reg   <= upper_mem[rd_idx];
            mid_rd_reg  <= middle_mem[rd_idx];
            fwd_up_reg  <= mid_raw;
            fwd_mid_reg <= wr_px;
        end
        if (wr_en)
        begin
            upper_mem[wr_idx]  <= mid_raw;
            middle_mem[wr_idx] <= wr_px;
        end
    end

    // forward the entry written this cycle to the read issued in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else if (rd_en)
            fwd_reg <= wr_en && (wr_idx == rd_idx);
    end

endmodule

### rtl/core/ipr_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Isolated pixel removal window
// 3x3 window register and the isolated center test.
// ----------------------------------------------------------------------------
module ipr_window (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  ipr_pkg::ipr_op_t  op,
    input  logic              up_raw,
    input  logic              mid_raw,
    output logic              push,
    output ipr_pkg::ipr_res_t res
);
    import ipr_pkg::*;

    logic [8:0] win_reg, win_next, win_shift, view;
    logic [2:0] col3;
    logic       col0_reg, col0_next, col0_now;

    always_comb
    begin
        col3 = {op.px, op.mid_en & mid_raw, op.top_en & up_raw};
        if (op.at_edge)
        begin
            view      = {3'b000, win_reg[8:3]};
            win_shift = {col3, 6'b000000};
        end
        else
        begin
            win_shift = {col3, win_reg[8:3]};
            view      = win_shift;
        end

        col0_now  = (op.wr && op.at_col0) ? op.px : col0_reg;
        col0_next = col0_reg;
        win_next  = win_reg;
        if (op_valid)
        begin
            col0_next = col0_now;
            if (op.clr)
                win_next = '0;
            else if (op.extra)
                win_next = {1'b0, col0_now, 7'b0000000};
            else
                win_next = win_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            col0_reg <= 1'b0;
        end
        else
        begin
            win_reg  <= win_next;
            col0_reg <= col0_next;
        end
    end

    assign push           = op_valid & op.res;
    assign res.pixel_out  = view[WIN_CENTER] & (|(view & WIN_NEIGHBOR_MASK));
    assign res.frame_last = op.last;

endmodule

### rtl/core/ipr_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Isolated pixel removal output queue
// Small result queue that decouples the filter from the receiver.
// ----------------------------------------------------------------------------
module ipr_out_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  ipr_pkg::ipr_res_t             push_data,
    input  logic                          pop,
    output logic                          out_valid,
    output ipr_pkg::ipr_res_t             out_data,
    output logic [ipr_pkg::OUT_CNT_W-1:0] count
);
    import ipr_pkg::*;

    ipr_res_t             entry_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + OUT_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - OUT_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

### rtl/core/isolated_pixel_removal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Isolated pixel removal
// Clears every set pixel of a binary raster frame whose eight neighbors are
// all clear; neighbors outside the frame count as clear.
//
// pixels: kind 0 carries one pixel in raster order, kind 1 is a flush tick.
//   After the last pixel of a frame the sender gives W+1 flush ticks (W when
//   the frame has one row); the last result carries frame_last.
// results: one filtered pixel per transaction, in raster order. The result
//   of a pixel trails it by one row plus one pixel of input transactions.
// cfg: register 0 frame_width, register 1 frame_height; write only between
//   frames. ready is always high.
// Throughput: one transaction per cycle while pixels.ready is high. Each item
//   reads both line memories at its column on acceptance; a pixel writes them
//   back in the next cycle, and any result the item completes is queued then.
// Reset: counters and window clear; the line memories are not cleared.
// Stall: a four-entry result queue absorbs the result in flight; pixels.ready
//   drops only when the queue cannot take another result.
// ----------------------------------------------------------------------------
module isolated_pixel_removal #(
    parameter int MAX_WIDTH = 2048
) (
    input logic        clk,
    input logic        rst_n,
    ipr_cfg_if.sink    cfg,
    ipr_in_if.sink     pixels,
    ipr_out_if.source  results
);
    import ipr_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                 accept;
    logic [COL_W-1:0]     rd_idx, op_idx;
    logic                 op_valid;
    ipr_op_t              op;
    logic                 up_raw, mid_raw;
    logic                 push;
    ipr_res_t             push_data, out_data;
    logic [OUT_CNT_W-1:0] fifo_count;

    assign cfg.ready    = 1'b1;
    assign pixels.ready = op_valid ? (fifo_count < OUT_CNT_W'(OUT_DEPTH - 1))
                                   : (fifo_count < OUT_CNT_W'(OUT_DEPTH));
    assign accept       = pixels.valid & pixels.ready;

    ipr_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg.valid & cfg.ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .accept    (accept),
        .kind      (pixels.kind),
        .pixel_in  (pixels.pixel_in),
        .rd_idx    (rd_idx),
        .op_valid  (op_valid),
        .op        (op),
        .op_idx    (op_idx)
    );

    ipr_lines #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lines (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (rd_idx),
        .wr_en   (op_valid & op.wr),
        .wr_idx  (op_idx),
        .wr_px   (op.px),
        .up_raw  (up_raw),
        .mid_raw (mid_raw)
    );

    ipr_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .up_raw   (up_raw),
        .mid_raw  (mid_raw),
        .push     (push),
        .res      (push_data)
    );

    ipr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (results.valid & results.ready),
        .out_valid (results.valid),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    assign results.pixel_out  = out_data.pixel_out;
    assign results.frame_last = out_data.frame_last;

endmodule

### verif/isolated_pixel_removal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Isolated pixel removal testbench
// Streams binary frames with their flush ticks through the block and checks
// each filtered pixel against a line-store and window predictor kept here.
// Frame sizes change between frames only, after the results have drained.
// Directed frames cover lone pixels, single rows and columns, stray flushes
// and pixels sent in place of flushes. Register extremes and a long output
// stall follow, then random frames with idle cycles on both sides.
// ----------------------------------------------------------------------------
module isolated_pixel_removal_tb;
    import ipr_pkg::*;

    localparam int          LINE_DEPTH     = 2048;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int unsigned RANDOM_ITEMS   = 600;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hF;

    logic clk = 1'b0;
    logic rst_n;

    ipr_in_if  pixels();
    ipr_out_if results();
    ipr_cfg_if cfg();

    isolated_pixel_removal #(
        .MAX_WIDTH (LINE_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .pixels  (pixels),
        .results (results)
    );

    logic [FW_W-1:0] frame_w = FRAME_WIDTH_RST;
    logic [FH_W-1:0] frame_h = FRAME_HEIGHT_RST;
    logic            upper_bits [LINE_DEPTH];
    logic            middle_bits [LINE_DEPTH];
    logic [8:0]      win = '0;
    int unsigned     col_at = 0;
    int unsigned     row_at = 0;
    int unsigned     flush_owed = 0;

    ipr_res_t        filtered_due[$];
    ipr_res_t        due_head;
    int unsigned     items_sent = 0;
    int unsigned     errors = 0;
    int unsigned     quiet_cycles = 0;
    int unsigned     hold_left = 0;
    bit              idle_en = 1'b1;

    always #2 clk = ~clk;

    function automatic int unsigned line_len();
        if (frame_w == 0)
            return 1;
        if (frame_w > LINE_DEPTH)
            return LINE_DEPTH;
        return frame_w;
    endfunction

    function automatic int unsigned frame_rows();
        if (frame_h == 0)
            return 1;
        if (frame_h > HEIGHT_LIMIT)
            return HEIGHT_LIMIT;
        return frame_h;
    endfunction

    // column: bit 0 top, bit 1 middle, bit 2 bottom row
    function automatic logic slide(input logic [2:0] column, input logic at_edge);
        logic [8:0] view;
        if (at_edge)
        begin
            view = {3'b000, win[8:3]};
            win  = {column, 6'b000000};
        end
        else
        begin
            win  = {column, win[8:3]};
            view = win;
        end
        return view[WIN_CENTER] && (|(view & WIN_NEIGHBOR_MASK));
    endfunction

    function automatic void remove_isolated(input logic kind, input logic px);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        logic        top;
        logic        mid;
        logic        filtered;
        logic        last;
        logic        produces;
        ipr_res_t    due;
        w        = line_len();
        h        = frame_rows();
        x        = col_at;
        y        = row_at;
        last     = 1'b0;
        produces = 1'b1;
        if (flush_owed == 0)
        begin
            if (kind == KIND_FLUSH)
                return;
            top            = (y >= 2) ? upper_bits[x] : 1'b0;
            mid            = (y >= 1) ? middle_bits[x] : 1'b0;
            upper_bits[x]  = middle_bits[x];
            middle_bits[x] = px;
            produces       = (y >= 1 && x >= 1) || (y >= 2 && x == 0);
            filtered       = slide({px, mid, top}, x == 0);
            if (x + 1 >= w)
            begin
                col_at = 0;
                if (y + 1 >= h)
                begin
                    flush_owed = w + 1;
                    if (y == 0)
                    begin
                        void'(slide({1'b0, middle_bits[0], 1'b0}, 1'b1));
                        col_at     = (w > 1) ? 1 : 0;
                        flush_owed = w;
                    end
                end
                else
                    row_at = y + 1;
            end
            else
                col_at = x + 1;
        end
        else
        begin
            last     = (flush_owed == 1);
            top      = (row_at >= 1) ? upper_bits[x] : 1'b0;
            mid      = middle_bits[x];
            filtered = slide({1'b0, mid, top}, x == 0 || last);
            flush_owed--;
            if (flush_owed == 0)
            begin
                row_at = 0;
                col_at = 0;
                win    = '0;
            end
            else
                col_at = (x + 1 >= w) ? 0 : x + 1;
        end
        if (produces)
        begin
            due.pixel_out  = filtered;
            due.frame_last = last;
            filtered_due   = {filtered_due, due};
        end
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic send_item(input logic kind, input logic px);
        if (idle_en)
        begin
            while ($urandom_range(99) < 12)
            begin
                pixels.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pixels.valid    <= 1'b1;
        pixels.kind     <= kind;
        pixels.pixel_in <= px;
        @(posedge clk);
        while (pixels.ready !== 1'b1)
            @(posedge clk);
        if (!(kind == KIND_FLUSH && flush_owed == 0))
            items_sent++;
        remove_isolated(kind, px);
    endtask

    // hold off new pixels until every filtered pixel is back and the block is quiet
    task automatic settle();
        pixels.valid <= 1'b0;
        while (filtered_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (cfg.ready !== 1'b1)
            @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH:  frame_w = value[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_h = value[FH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        settle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        cfg.valid <= 1'b0;
    endtask

    // send pixels up to the frame end, then flush ticks with some pixels in their place
    task automatic send_frame(input int unsigned density, input int unsigned noise);
        do
        begin
            send_item(KIND_PIXEL, $urandom_range(99) < density);
        end
        while (flush_owed == 0);
        while (flush_owed != 0)
            send_item(($urandom_range(99) < noise) ? KIND_PIXEL : KIND_FLUSH,
                      1'($urandom_range(1)));
    endtask

    task automatic test_idle_flush();
        send_item(KIND_FLUSH, 1'b0);
        send_item(KIND_FLUSH, 1'b1);
    endtask

    task automatic test_lone_pixel();
        logic [8:0] pattern;
        pattern = 9'b000_010_000;
        set_frame(13'd3, 13'd3);
        for (int i = 0; i < 9; i++)
            send_item(KIND_PIXEL, pattern[i]);
        while (flush_owed != 0)
            send_item(flush_owed[0] ? KIND_PIXEL : KIND_FLUSH, 1'b1);
    endtask

    task automatic test_single_row();
        logic [3:0] pattern;
        pattern = 4'b1101;
        set_frame(13'd4, 13'd1);
        for (int i = 0; i < 4; i++)
            send_item(KIND_PIXEL, pattern[i]);
        while (flush_owed != 0)
            send_item(KIND_FLUSH, 1'b0);
    endtask

    task automatic test_single_pixel();
        set_frame(13'd1, 13'd1);
        send_item(KIND_PIXEL, 1'b1);
        send_item(KIND_FLUSH, 1'b0);
        send_item(KIND_PIXEL, 1'b1);
        send_item(KIND_PIXEL, 1'b0);
    endtask

    task automatic test_register_extremes();
        set_frame(13'd0, 13'd3);
        send_frame(50, 0);
        set_frame(13'd6, 13'd0);
        send_frame(50, 0);
        set_frame(13'd2, 13'd5);
        send_frame(20, 5);
        settle();
        write_reg(REG_UNMAPPED, 13'h1FFF);
        write_reg(REG_FRAME_WIDTH, 13'h1005);
        write_reg(REG_FRAME_HEIGHT, 13'd4);
        cfg.valid <= 1'b0;
        send_frame(30, 5);
    endtask

    task automatic test_backpressure();
        set_frame(13'd8, 13'd8);
        hold_left = HOLD_CYCLES;
        send_frame(50, 0);
        settle();
    endtask

    task automatic test_random_frames();
        int unsigned start;
        int unsigned done;
        start = items_sent;
        done  = 0;
        while (done < RANDOM_ITEMS)
        begin
            idle_en = !(done >= 250 && done < 450);
            if ($urandom_range(1))
            begin
                if ($urandom_range(99) < 10)
                    set_frame(CFG_DATA_W'($urandom_range(40)),
                              CFG_DATA_W'($urandom_range(8)));
                else
                    set_frame(CFG_DATA_W'($urandom_range(8)),
                              CFG_DATA_W'($urandom_range(8)));
            end
            while ($urandom_range(99) < 20)
                send_item(KIND_FLUSH, 1'($urandom_range(1)));
            send_frame(5 + 25 * $urandom_range(3), 15);
            done = items_sent - start;
        end
        idle_en = 1'b1;
    endtask

    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                results.ready <= 1'b0;
                hold_left--;
            end
            else
                results.ready <= !(idle_en && $urandom_range(99) < 12);
        end
    end

    always @(posedge clk)
    begin
        if (results.valid === 1'b1 && results.ready === 1'b1)
        begin
            if (filtered_due.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                due_head = filtered_due.pop_front();
                if (results.pixel_out !== due_head.pixel_out)
                    report_mismatch($sformatf("pixel_out got %b want %b",
                                              results.pixel_out, due_head.pixel_out));
                if (results.frame_last !== due_head.frame_last)
                    report_mismatch($sformatf("frame_last got %b want %b",
                                              results.frame_last, due_head.frame_last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pixels.valid === 1'b1 && pixels.ready === 1'b1) ||
            (results.valid === 1'b1 && results.ready === 1'b1) ||
            (cfg.valid === 1'b1 && cfg.ready === 1'b1))
            quiet_cycles = 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL isolated_pixel_removal");
            $finish;
        end
        else
            quiet_cycles++;
    end

    initial
    begin
        rst_n           = 1'b0;
        pixels.valid    = 1'b0;
        pixels.kind     = KIND_PIXEL;
        pixels.pixel_in = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = REG_FRAME_WIDTH;
        cfg.data        = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_flush();
        test_lone_pixel();
        test_single_row();
        test_single_pixel();
        test_register_extremes();
        test_backpressure();
        test_random_frames();
        settle();
        if (errors == 0 && filtered_due.size() == 0)
            $display("PASS isolated_pixel_removal");
        else
            $display("FAIL isolated_pixel_removal");
        $finish;
    end

endmodule

### sim.f
rtl/core/ipr_pkg.sv
rtl/core/ipr_if.sv
rtl/core/ipr_seq.sv
rtl/core/ipr_lines.sv
rtl/core/ipr_window.sv
rtl/core/ipr_out_fifo.sv
rtl/core/isolated_pixel_removal.sv
verif/isolated_pixel_removal_tb.sv
